// ===== hw/rtl/avcp_pkg.sv =====
// ----------------------------------------------------------------------------
// avcp_pkg
// Shared widths, codes and word types of the AVC configuration record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package avcp_pkg;

  localparam int DATA_W     = 8;
  localparam int SEQ_W      = 5;
  localparam int PIC_W      = 8;
  localparam int INDEX_W    = 8;
  localparam int LEN_W      = 16;
  localparam int CONSUMED_W = 20;
  localparam int KIND_W     = 4;
  localparam int STATUS_W   = 3;

  localparam int DEF_MIN_RECORD_BYTES = 7;
  localparam int DEF_COUNT_WIDTH      = 20;

  // length-size byte: low two bits must read 3
  localparam logic [1:0] LENSIZE_OK = 2'b11;

  // configuration register map
  localparam int  ADDR_W      = 3;
  localparam int  APB_DATA_W  = 32;
  localparam logic REG_SEQ_CAP = 1'b0;
  localparam logic REG_PIC_CAP = 1'b1;

  localparam logic [SEQ_W-1:0] SEQ_CAP_RESET = '1;
  localparam logic [PIC_W-1:0] PIC_CAP_RESET = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERSION  = 4'd0,
    KIND_PROFILE  = 4'd1,
    KIND_COMPAT   = 4'd2,
    KIND_LEVEL    = 4'd3,
    KIND_LENSIZE  = 4'd4,
    KIND_SPS_CNT  = 4'd5,
    KIND_SPS_LEN  = 4'd6,
    KIND_SPS_DATA = 4'd7,
    KIND_PPS_CNT  = 4'd8,
    KIND_PPS_LEN  = 4'd9,
    KIND_PPS_DATA = 4'd10,
    KIND_IGNORED  = 4'd11
  } avcp_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_BUSY      = 3'd0,
    ST_OK        = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_TOO_MANY  = 3'd4
  } avcp_status_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first_byte;
    logic              last_byte;
  } avcp_item_t;

  typedef struct packed {
    avcp_kind_t            byte_kind;
    logic [INDEX_W-1:0]    set_index;
    logic [DATA_W-1:0]     echo_byte;
    logic                  set_start;
    logic                  set_end;
    logic                  set_stored;
    logic                  done_res;
    avcp_status_t          status;
    logic [CONSUMED_W-1:0] consumed_bytes;
    logic [SEQ_W-1:0]      seq_set_total;
    logic [PIC_W-1:0]      pic_set_total;
  } avcp_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/avcp_in_if.sv =====
// ----------------------------------------------------------------------------
// avcp_in_if
// Byte channel into the parser: one record byte with buffer markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface avcp_in_if
  import avcp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/avcp_out_if.sv =====
// ----------------------------------------------------------------------------
// avcp_out_if
// Tag channel out of the parser: one tag word per record byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface avcp_out_if
  import avcp_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     byte_kind;
  logic [INDEX_W-1:0]    set_index;
  logic [DATA_W-1:0]     echo_byte;
  logic                  set_start;
  logic                  set_end;
  logic                  set_stored;
  logic                  done_res;
  logic [STATUS_W-1:0]   status;
  logic [CONSUMED_W-1:0] consumed_bytes;
  logic [SEQ_W-1:0]      seq_set_total;
  logic [PIC_W-1:0]      pic_set_total;

  modport source (
    output valid, byte_kind, set_index, echo_byte, set_start, set_end, set_stored,
           done_res, status, consumed_bytes, seq_set_total, pic_set_total,
    input  ready
  );
  modport sink (
    input  valid, byte_kind, set_index, echo_byte, set_start, set_end, set_stored,
           done_res, status, consumed_bytes, seq_set_total, pic_set_total,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/avc_config_record_parser.sv =====
// ----------------------------------------------------------------------------
// avc_config_record_parser
// Tags each byte of an AVC decoder configuration record and gives a verdict.
//
//   channel  dir  kind        word
//   stream   in   valid/ready data_byte, first_byte, last_byte
//   result   out  valid/ready byte tag, set flags, verdict, totals
//   apb      in   APB write   seq_set_capacity @0x0, pic_set_capacity @0x4
//
// One byte per cycle sustained while results are taken; each tag passes the input
// register, then the result register, before it shows on the result channel.
// Synchronous reset restores parse state and capacities; no clearing pass.
// A stalled result holds the tag; the input register still takes one byte,
// then ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module avc_config_record_parser
  import avcp_pkg::*;
#(
  parameter int MIN_RECORD_BYTES = DEF_MIN_RECORD_BYTES,
  parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  avcp_in_if.sink                    stream,
  avcp_out_if.source                 result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic             seq_set_capacity;
  logic [SEQ_W-1:0] seq_cap;
  logic [PIC_W-1:0] pic_cap;

  logic         in_valid;
  avcp_item_t   in_item;
  logic         out_valid;
  avcp_result_t out_res;
  avcp_result_t core_res;
  logic         advance;
  logic         wr;

  // register file
  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign seq_set_capacity = (paddr[2] == REG_SEQ_CAP);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cap <= SEQ_CAP_RESET;
      pic_cap <= PIC_CAP_RESET;
    end else if (wr) begin
      if (seq_set_capacity) begin
        seq_cap <= pwdata[SEQ_W-1:0];
      end else begin
        pic_cap <= pwdata[PIC_W-1:0];
      end
    end
  end

  assign prdata = seq_set_capacity ? APB_DATA_W'(seq_cap) : APB_DATA_W'(pic_cap);

  // pipeline control
  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_item.data_byte  <= stream.data_byte;
      in_item.first_byte <= stream.first_byte;
      in_item.last_byte  <= stream.last_byte;
    end
  end

  avcp_parse #(
    .MIN_RECORD_BYTES (MIN_RECORD_BYTES),
    .COUNT_WIDTH      (COUNT_WIDTH)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .item    (in_item),
    .seq_cap (seq_cap),
    .pic_cap (pic_cap),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.byte_kind      = out_res.byte_kind;
  assign result.set_index      = out_res.set_index;
  assign result.echo_byte      = out_res.echo_byte;
  assign result.set_start      = out_res.set_start;
  assign result.set_end        = out_res.set_end;
  assign result.set_stored     = out_res.set_stored;
  assign result.done_res       = out_res.done_res;
  assign result.status         = out_res.status;
  assign result.consumed_bytes = out_res.consumed_bytes;
  assign result.seq_set_total  = out_res.seq_set_total;
  assign result.pic_set_total  = out_res.pic_set_total;

endmodule

`default_nettype wire

// ===== hw/rtl/avcp_parse.sv =====
// ----------------------------------------------------------------------------
// avcp_parse
// Parse state and per-byte tagging: one byte is consumed on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module avcp_parse
  import avcp_pkg::*;
#(
  parameter int MIN_RECORD_BYTES = DEF_MIN_RECORD_BYTES,
  parameter int COUNT_WIDTH      = DEF_COUNT_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire avcp_item_t       item,
  input  wire logic [SEQ_W-1:0] seq_cap,
  input  wire logic [PIC_W-1:0] pic_cap,
  output avcp_result_t          res
);

  localparam int PosW = (COUNT_WIDTH < CONSUMED_W) ? COUNT_WIDTH : CONSUMED_W;
  localparam logic [PosW-1:0] MinCnt = PosW'(MIN_RECORD_BYTES);

  typedef enum logic [15:0] {
    PH_VERSION     = 16'h0001,
    PH_PROFILE     = 16'h0002,
    PH_COMPAT      = 16'h0004,
    PH_LEVEL       = 16'h0008,
    PH_LENSIZE     = 16'h0010,
    PH_SCOUNT      = 16'h0020,
    PH_SLEN_HI     = 16'h0040,
    PH_SLEN_LO     = 16'h0080,
    PH_SDATA_FIRST = 16'h0100,
    PH_SDATA       = 16'h0200,
    PH_PCOUNT      = 16'h0400,
    PH_PLEN_HI     = 16'h0800,
    PH_PLEN_LO     = 16'h1000,
    PH_PDATA_FIRST = 16'h2000,
    PH_PDATA       = 16'h4000,
    PH_HOLD        = 16'h8000
  } avcp_phase_t;

  avcp_phase_t        phase, phase_next;
  logic [PosW-1:0]    byte_position, byte_position_next;
  logic [INDEX_W-1:0] set_counter, set_counter_next;
  logic [DATA_W-1:0]  length_high, length_high_next;
  logic [LEN_W-1:0]   payload_left, payload_left_next;
  logic [SEQ_W-1:0]   seq_total, seq_total_next;
  logic [PIC_W-1:0]   pic_total, pic_total_next;
  logic               length_size_bad, length_size_bad_next;
  logic               finished, finished_next;

  avcp_phase_t           cur_phase;
  logic [PosW-1:0]       cur_pos, cnt;
  logic [INDEX_W-1:0]    cur_setc, setc_inc;
  logic [DATA_W-1:0]     cur_lenhi;
  logic [LEN_W-1:0]      cur_payl, payl_dec, len;
  logic [SEQ_W-1:0]      cur_seq;
  logic [PIC_W-1:0]      cur_pic;
  logic                  cur_lsb, cur_fin;
  logic                  conc;
  logic [CONSUMED_W-1:0] conc_val;
  avcp_status_t          fstat;
  logic [DATA_W-1:0]     b;

  always_comb begin
    b         = item.data_byte;
    cur_phase = item.first_byte ? PH_VERSION : phase;
    cur_pos   = item.first_byte ? '0 : byte_position;
    cur_setc  = item.first_byte ? '0 : set_counter;
    cur_lenhi = item.first_byte ? '0 : length_high;
    cur_payl  = item.first_byte ? '0 : payload_left;
    cur_seq   = item.first_byte ? '0 : seq_total;
    cur_pic   = item.first_byte ? '0 : pic_total;
    cur_lsb   = item.first_byte ? 1'b0 : length_size_bad;
    cur_fin   = item.first_byte ? 1'b0 : finished;

    cnt      = (cur_pos != '1) ? cur_pos + 1'b1 : cur_pos;
    setc_inc = cur_setc + 1'b1;
    payl_dec = cur_payl - 1'b1;
    len      = {cur_lenhi, b};

    phase_next           = cur_phase;
    byte_position_next   = cur_pos;
    set_counter_next     = cur_setc;
    length_high_next     = cur_lenhi;
    payload_left_next    = cur_payl;
    seq_total_next       = cur_seq;
    pic_total_next       = cur_pic;
    length_size_bad_next = cur_lsb;
    finished_next        = cur_fin;

    conc     = 1'b0;
    conc_val = '0;
    fstat    = ST_OK;

    res                = '0;
    res.byte_kind      = KIND_IGNORED;
    res.status         = ST_BUSY;
    res.echo_byte      = b;

    if (!cur_fin) begin
      byte_position_next = cnt;
      case (cur_phase)
        PH_VERSION: begin
          res.byte_kind = KIND_VERSION;
          phase_next    = PH_PROFILE;
        end
        PH_PROFILE: begin
          res.byte_kind = KIND_PROFILE;
          phase_next    = PH_COMPAT;
        end
        PH_COMPAT: begin
          res.byte_kind = KIND_COMPAT;
          phase_next    = PH_LEVEL;
        end
        PH_LEVEL: begin
          res.byte_kind = KIND_LEVEL;
          phase_next    = PH_LENSIZE;
        end
        PH_LENSIZE: begin
          res.byte_kind = KIND_LENSIZE;
          if (b[1:0] != LENSIZE_OK) begin
            length_size_bad_next = 1'b1;
            conc                 = 1'b1;
            conc_val             = CONSUMED_W'(4);
          end else begin
            phase_next = PH_SCOUNT;
          end
        end
        PH_SCOUNT: begin
          res.byte_kind    = KIND_SPS_CNT;
          seq_total_next   = b[SEQ_W-1:0];
          set_counter_next = '0;
          phase_next       = (b[SEQ_W-1:0] == '0) ? PH_PCOUNT : PH_SLEN_HI;
        end
        PH_SLEN_HI, PH_SLEN_LO: begin
          res.byte_kind  = KIND_SPS_LEN;
          res.set_index  = cur_setc;
          res.set_stored = cur_setc < INDEX_W'(seq_cap);
          if (cur_phase == PH_SLEN_HI) begin
            length_high_next = b;
            phase_next       = PH_SLEN_LO;
          end else if (len == '0) begin
            res.set_end      = 1'b1;
            set_counter_next = setc_inc;
            phase_next       = (setc_inc >= INDEX_W'(cur_seq)) ? PH_PCOUNT : PH_SLEN_HI;
          end else begin
            payload_left_next = len;
            phase_next        = PH_SDATA_FIRST;
          end
        end
        PH_SDATA_FIRST, PH_SDATA: begin
          res.byte_kind     = KIND_SPS_DATA;
          res.set_index     = cur_setc;
          res.set_stored    = cur_setc < INDEX_W'(seq_cap);
          res.set_start     = (cur_phase == PH_SDATA_FIRST);
          phase_next        = PH_SDATA;
          payload_left_next = payl_dec;
          if (payl_dec == '0) begin
            res.set_end      = 1'b1;
            set_counter_next = setc_inc;
            phase_next       = (setc_inc >= INDEX_W'(cur_seq)) ? PH_PCOUNT : PH_SLEN_HI;
          end
        end
        PH_PCOUNT: begin
          res.byte_kind    = KIND_PPS_CNT;
          pic_total_next   = b;
          set_counter_next = '0;
          if (b == '0) begin
            conc     = 1'b1;
            conc_val = CONSUMED_W'(cnt);
          end else begin
            phase_next = PH_PLEN_HI;
          end
        end
        PH_PLEN_HI, PH_PLEN_LO: begin
          res.byte_kind  = KIND_PPS_LEN;
          res.set_index  = cur_setc;
          res.set_stored = cur_setc < INDEX_W'(pic_cap);
          if (cur_phase == PH_PLEN_HI) begin
            length_high_next = b;
            phase_next       = PH_PLEN_LO;
          end else if (len == '0) begin
            res.set_end      = 1'b1;
            set_counter_next = setc_inc;
            if (setc_inc >= INDEX_W'(cur_pic)) begin
              conc     = 1'b1;
              conc_val = CONSUMED_W'(cnt);
            end else begin
              phase_next = PH_PLEN_HI;
            end
          end else begin
            payload_left_next = len;
            phase_next        = PH_PDATA_FIRST;
          end
        end
        PH_PDATA_FIRST, PH_PDATA: begin
          res.byte_kind     = KIND_PPS_DATA;
          res.set_index     = cur_setc;
          res.set_stored    = cur_setc < INDEX_W'(pic_cap);
          res.set_start     = (cur_phase == PH_PDATA_FIRST);
          phase_next        = PH_PDATA;
          payload_left_next = payl_dec;
          if (payl_dec == '0) begin
            res.set_end      = 1'b1;
            set_counter_next = setc_inc;
            if (setc_inc >= INDEX_W'(cur_pic)) begin
              conc     = 1'b1;
              conc_val = CONSUMED_W'(cnt);
            end else begin
              phase_next = PH_PLEN_HI;
            end
          end
        end
        default: begin
          // verdict held until enough bytes have arrived
          res.byte_kind = KIND_IGNORED;
          conc          = 1'b1;
          conc_val      = CONSUMED_W'(cur_payl);
        end
      endcase

      if (length_size_bad_next) begin
        fstat = ST_BAD_LEN;
      end else if (seq_total_next > seq_cap || pic_total_next > pic_cap) begin
        fstat = ST_TOO_MANY;
      end

      if (conc) begin
        if (cnt >= MinCnt) begin
          finished_next      = 1'b1;
          res.done_res       = 1'b1;
          res.status         = fstat;
          res.consumed_bytes = conc_val;
        end else begin
          phase_next        = PH_HOLD;
          payload_left_next = conc_val[LEN_W-1:0];
        end
      end

      if (item.last_byte && !finished_next) begin
        finished_next      = 1'b1;
        res.done_res       = 1'b1;
        res.status         = ST_TRUNCATED;
        res.consumed_bytes = '0;
      end
    end

    res.seq_set_total = seq_total_next;
    res.pic_set_total = pic_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_VERSION;
      byte_position   <= '0;
      set_counter     <= '0;
      length_high     <= '0;
      payload_left    <= '0;
      seq_total       <= '0;
      pic_total       <= '0;
      length_size_bad <= 1'b0;
      finished        <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      set_counter     <= set_counter_next;
      length_high     <= length_high_next;
      payload_left    <= payload_left_next;
      seq_total       <= seq_total_next;
      pic_total       <= pic_total_next;
      length_size_bad <= length_size_bad_next;
      finished        <= finished_next;
    end
  end

`ifndef SYNTHESIS
  a_done_latches: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> finished)
    else $error("verdict given but parse not marked finished");

  a_finished_quiet: assert property (@(posedge clk) disable iff (rst)
    step && finished && !item.first_byte |->
      res.byte_kind == KIND_IGNORED && !res.done_res && res.status == ST_BUSY)
    else $error("byte after verdict not ignored");

  a_trunc_shape: assert property (@(posedge clk) disable iff (rst)
    step && res.status == ST_TRUNCATED |-> item.last_byte && res.consumed_bytes == '0)
    else $error("truncation verdict without last byte or with nonzero count");

  a_status_done: assert property (@(posedge clk) disable iff (rst)
    step && !res.done_res |-> res.status == ST_BUSY && res.consumed_bytes == '0)
    else $error("status or count given without verdict");
`endif

endmodule

`default_nettype wire

// ===== bench/avc_config_record_parser_tb.sv =====
// ----------------------------------------------------------------------------
// avc_config_record_parser_tb
// Self-checking bench for the AVC configuration record parser. Record buffers,
// broken buffers and stray bytes are pushed through the byte channel with random
// gaps and result stalls. Each accepted byte is run through a local model of the
// parser, and every tag word that comes out is compared field by field.
// Capacities are rewritten over APB between phases, once the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module avc_config_record_parser_tb;
  import avcp_pkg::*;

  typedef enum logic [3:0] {
    PH_VERSION, PH_PROFILE, PH_COMPAT, PH_LEVEL, PH_LENSIZE,
    PH_SEQ_COUNT, PH_SEQ_LEN_HI, PH_SEQ_LEN_LO, PH_SEQ_FIRST, PH_SEQ_DATA,
    PH_PIC_COUNT, PH_PIC_LEN_HI, PH_PIC_LEN_LO, PH_PIC_FIRST, PH_PIC_DATA,
    PH_HOLD
  } parse_phase_t;

  localparam int MIN_BYTES = DEF_MIN_RECORD_BYTES;
  localparam longint COUNT_RAW_MAX = (64'd1 << DEF_COUNT_WIDTH) - 1;
  localparam int unsigned BYTE_COUNT_MAX =
    (COUNT_RAW_MAX > 64'hFFFFF) ? 32'hFFFFF : int'(COUNT_RAW_MAX);
  localparam logic [ADDR_W-1:0] SEQ_CAP_ADDR = ADDR_W'(4 * int'(REG_SEQ_CAP));
  localparam logic [ADDR_W-1:0] PIC_CAP_ADDR = ADDR_W'(4 * int'(REG_PIC_CAP));

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  avcp_in_if  in_if ();
  avcp_out_if out_if ();

  avc_config_record_parser DUT (
    .clk     (clk),
    .rst     (rst),
    .stream  (in_if),
    .result  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // parser model state
  parse_phase_t     ph;
  int unsigned      byte_pos;
  logic [7:0]       set_cnt;
  logic [7:0]       len_hi;
  logic [15:0]      left;
  logic [SEQ_W-1:0] seq_tot;
  logic [PIC_W-1:0] pic_tot;
  logic             len_bad;
  logic             fin;
  logic [SEQ_W-1:0] cap_seq;
  logic [PIC_W-1:0] cap_pic;

  avcp_result_t pending_tags[$];
  int  mismatch_count = 0;
  int  byte_count = 0;
  bit  idle_on = 1'b1;
  int  ready_stall = 0;
  avcp_result_t seen_tag;

  function automatic void clear_parse();
    ph = PH_VERSION;
    byte_pos = 0;
    set_cnt = '0;
    len_hi = '0;
    left = '0;
    seq_tot = '0;
    pic_tot = '0;
    len_bad = 1'b0;
    fin = 1'b0;
  endfunction

  function automatic avcp_status_t verdict();
    if (len_bad) return ST_BAD_LEN;
    if (seq_tot > cap_seq || pic_tot > cap_pic) return ST_TOO_MANY;
    return ST_OK;
  endfunction

  // record over after `consumed` bytes; verdict held until enough bytes are in
  function automatic void conclude(input int unsigned consumed, input int unsigned seen,
                                   inout avcp_result_t r);
    if (seen >= MIN_BYTES) begin
      fin = 1'b1;
      r.done_res = 1'b1;
      r.status = verdict();
      r.consumed_bytes = CONSUMED_W'(consumed);
    end else begin
      ph = PH_HOLD;
      left = consumed[15:0];
    end
  endfunction

  function automatic void next_seq_set();
    set_cnt = set_cnt + 8'd1;
    ph = (set_cnt >= seq_tot) ? PH_PIC_COUNT : PH_SEQ_LEN_HI;
  endfunction

  function automatic void next_pic_set(input int unsigned cnt, inout avcp_result_t r);
    set_cnt = set_cnt + 8'd1;
    if (set_cnt >= pic_tot) conclude(cnt, cnt, r);
    else ph = PH_PIC_LEN_HI;
  endfunction

  function automatic avcp_result_t predict_tag(input avcp_item_t w);
    avcp_result_t r;
    int unsigned cnt;
    logic [15:0] len;
    logic [7:0] b;
    b = w.data_byte;
    if (w.first_byte) clear_parse();
    r = '0;
    r.echo_byte = b;
    cnt = byte_pos;
    if (cnt < BYTE_COUNT_MAX) cnt++;
    if (fin) begin
      r.byte_kind = KIND_IGNORED;
    end else begin
      byte_pos = cnt;
      case (ph)
        PH_VERSION: begin
          r.byte_kind = KIND_VERSION;
          ph = PH_PROFILE;
        end
        PH_PROFILE: begin
          r.byte_kind = KIND_PROFILE;
          ph = PH_COMPAT;
        end
        PH_COMPAT: begin
          r.byte_kind = KIND_COMPAT;
          ph = PH_LEVEL;
        end
        PH_LEVEL: begin
          r.byte_kind = KIND_LEVEL;
          ph = PH_LENSIZE;
        end
        PH_LENSIZE: begin
          r.byte_kind = KIND_LENSIZE;
          if (b[1:0] != LENSIZE_OK) begin
            len_bad = 1'b1;
            conclude(4, cnt, r);
          end else begin
            ph = PH_SEQ_COUNT;
          end
        end
        PH_SEQ_COUNT: begin
          r.byte_kind = KIND_SPS_CNT;
          seq_tot = b[SEQ_W-1:0];
          set_cnt = '0;
          ph = (seq_tot == 0) ? PH_PIC_COUNT : PH_SEQ_LEN_HI;
        end
        PH_SEQ_LEN_HI, PH_SEQ_LEN_LO: begin
          r.byte_kind = KIND_SPS_LEN;
          r.set_index = set_cnt;
          r.set_stored = set_cnt < cap_seq;
          if (ph == PH_SEQ_LEN_HI) begin
            len_hi = b;
            ph = PH_SEQ_LEN_LO;
          end else begin
            len = {len_hi, b};
            if (len == 0) begin
              r.set_end = 1'b1;
              next_seq_set();
            end else begin
              left = len;
              ph = PH_SEQ_FIRST;
            end
          end
        end
        PH_SEQ_FIRST, PH_SEQ_DATA: begin
          r.byte_kind = KIND_SPS_DATA;
          r.set_index = set_cnt;
          r.set_stored = set_cnt < cap_seq;
          r.set_start = (ph == PH_SEQ_FIRST);
          ph = PH_SEQ_DATA;
          left = left - 16'd1;
          if (left == 0) begin
            r.set_end = 1'b1;
            next_seq_set();
          end
        end
        PH_PIC_COUNT: begin
          r.byte_kind = KIND_PPS_CNT;
          pic_tot = b;
          set_cnt = '0;
          if (pic_tot == 0) conclude(cnt, cnt, r);
          else ph = PH_PIC_LEN_HI;
        end
        PH_PIC_LEN_HI, PH_PIC_LEN_LO: begin
          r.byte_kind = KIND_PPS_LEN;
          r.set_index = set_cnt;
          r.set_stored = set_cnt < cap_pic;
          if (ph == PH_PIC_LEN_HI) begin
            len_hi = b;
            ph = PH_PIC_LEN_LO;
          end else begin
            len = {len_hi, b};
            if (len == 0) begin
              r.set_end = 1'b1;
              next_pic_set(cnt, r);
            end else begin
              left = len;
              ph = PH_PIC_FIRST;
            end
          end
        end
        PH_PIC_FIRST, PH_PIC_DATA: begin
          r.byte_kind = KIND_PPS_DATA;
          r.set_index = set_cnt;
          r.set_stored = set_cnt < cap_pic;
          r.set_start = (ph == PH_PIC_FIRST);
          ph = PH_PIC_DATA;
          left = left - 16'd1;
          if (left == 0) begin
            r.set_end = 1'b1;
            next_pic_set(cnt, r);
          end
        end
        default: begin
          r.byte_kind = KIND_IGNORED;
          if (cnt >= MIN_BYTES) begin
            fin = 1'b1;
            r.done_res = 1'b1;
            r.status = verdict();
            r.consumed_bytes = CONSUMED_W'(left);
          end
        end
      endcase
      if (w.last_byte && !fin) begin
        fin = 1'b1;
        r.done_res = 1'b1;
        r.status = ST_TRUNCATED;
        r.consumed_bytes = '0;
      end
    end
    r.seq_set_total = seq_tot;
    r.pic_set_total = pic_tot;
    return r;
  endfunction

  // ---- stimulus helpers ----

  task automatic send_byte(input avcp_item_t w);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= w.data_byte;
    in_if.first_byte <= w.first_byte;
    in_if.last_byte <= w.last_byte;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    pending_tags.push_back(predict_tag(w));
    byte_count++;
  endtask

  task automatic send_buffer(input logic [7:0] q[$], input int first_at, input int last_at);
    avcp_item_t w;
    for (int i = 0; i < q.size(); i++) begin
      w.data_byte = q[i];
      w.first_byte = (i == first_at);
      w.last_byte = (i == last_at);
      send_byte(w);
    end
  endtask

  function automatic void push_set(ref logic [7:0] q[$], input int lo, input int hi);
    logic [15:0] len;
    len = 16'($urandom_range(lo, hi));
    q.push_back(len[15:8]);
    q.push_back(len[7:0]);
    repeat (len) q.push_back(8'($urandom));
  endfunction

  function automatic void make_record(ref logic [7:0] q[$], input int n_seq, input int n_pic,
                                      input int lo, input int hi, input bit lensize_ok);
    logic [7:0] b;
    q.delete();
    repeat (4) q.push_back(8'($urandom));
    b = 8'($urandom);
    b[1:0] = lensize_ok ? LENSIZE_OK : 2'($urandom_range(0, 2));
    q.push_back(b);
    b = 8'($urandom);
    b[4:0] = 5'(n_seq);
    q.push_back(b);
    repeat (n_seq) push_set(q, lo, hi);
    q.push_back(8'(n_pic));
    repeat (n_pic) push_set(q, lo, hi);
  endfunction

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_tags.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_capacities(input int seq_cap, input int pic_cap);
    drain();
    apb_write(SEQ_CAP_ADDR, APB_DATA_W'(seq_cap));
    apb_write(PIC_CAP_ADDR, APB_DATA_W'(pic_cap));
    cap_seq = SEQ_W'(seq_cap);
    cap_pic = PIC_W'(pic_cap);
  endtask

  // ---- tests ----

  task automatic test_directed_records();
    logic [7:0] q[$];
    // no first marker after reset, zero counts, spare high bits in the count
    q = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'hFF, 8'hE0, 8'h00};
    send_buffer(q, -1, 6);
    // bad length size: verdict held until the minimum bytes are in
    q = '{8'h01, 8'h64, 8'h00, 8'h1F, 8'hFC, 8'h12, 8'h34, 8'h56};
    send_buffer(q, 0, 7);
    // bad length size, buffer ends while the verdict is held
    q = '{8'h01, 8'h42, 8'hC0, 8'h28, 8'hFD, 8'h00};
    send_buffer(q, 0, 5);
    // short buffer inside the header
    q = '{8'h01, 8'h4D, 8'h40};
    send_buffer(q, 0, 2);
    // ends before the picture set count
    q = '{8'h01, 8'h64, 8'h00, 8'h1E, 8'hFF, 8'hE1, 8'h00, 8'h00};
    send_buffer(q, 0, 7);
    // one set of each kind
    q = '{8'h01, 8'h64, 8'h00, 8'h1F, 8'h03, 8'h01, 8'h00, 8'h02, 8'hAB, 8'hCD,
          8'h01, 8'h00, 8'h01, 8'hEF};
    send_buffer(q, 0, 13);
  endtask

  task automatic test_count_extremes();
    logic [7:0] q[$];
    q = '{8'h01, 8'h64, 8'h00, 8'h1F, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h11,
          8'h22, 8'h33};
    send_buffer(q, 0, 11);
  endtask

  task automatic test_capacity_limits();
    logic [7:0] q[$];
    set_capacities(0, 0);
    make_record(q, 2, 3, 0, 3, 1);
    send_buffer(q, 0, q.size() - 1);
    make_record(q, 0, 0, 0, 0, 1);
    send_buffer(q, 0, q.size() - 1);
    set_capacities(31, 255);
    make_record(q, 31, 2, 0, 0, 1);
    send_buffer(q, 0, q.size() - 1);
    set_capacities(1, 2);
    make_record(q, 2, 2, 0, 3, 1);
    send_buffer(q, 0, q.size() - 1);
    make_record(q, 1, 3, 0, 3, 1);
    send_buffer(q, 0, q.size() - 1);
    make_record(q, 1, 2, 0, 3, 1);
    send_buffer(q, 0, q.size() - 1);
  endtask

  task automatic test_long_set();
    logic [7:0] q[$];
    make_record(q, 1, 0, 256, 260, 1);
    send_buffer(q, 0, q.size() - 1);
  endtask

  task automatic test_random_records(input int n_bytes);
    logic [7:0] q[$];
    avcp_item_t w;
    int stop_at;
    int pick;
    int last_at;
    int cut;
    stop_at = byte_count + n_bytes;
    while (byte_count < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        make_record(q, $urandom_range(0, 3), $urandom_range(0, 3), 0, 5, 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: last_at = q.size() - 1;
          6, 7: last_at = -1;
          default: last_at = $urandom_range(0, q.size() - 1);
        endcase
        repeat ($urandom_range(0, 2)) q.push_back(8'($urandom));
        send_buffer(q, 0, last_at);
      end else if (pick < 17) begin
        make_record(q, $urandom_range(0, 3), $urandom_range(0, 3), 0, 5, $urandom_range(0, 1));
        cut = $urandom_range(0, q.size() - 1);
        q = q[0:cut];
        send_buffer(q, 0, ($urandom_range(0, 1) == 1) ? cut : -1);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          w.data_byte = 8'($urandom);
          w.first_byte = ($urandom_range(0, 7) == 0);
          w.last_byte = ($urandom_range(0, 7) == 0);
          send_byte(w);
        end
      end
    end
  endtask

  task automatic test_unpaced_stream();
    logic [7:0] q[$];
    idle_on = 1'b0;
    set_capacities($urandom_range(0, 31), $urandom_range(0, 255));
    repeat (2) begin
      make_record(q, $urandom_range(0, 3), $urandom_range(0, 3), 0, 4, 1);
      send_buffer(q, 0, q.size() - 1);
    end
  endtask

  // ---- result checking ----

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_tag(input avcp_result_t got);
    avcp_result_t want;
    if (pending_tags.size() == 0) begin
      $display("%0t: tag word with none expected, actual %p", $time, got);
      mismatch_count++;
    end else begin
      want = pending_tags.pop_front();
      compare_field("byte_kind", want.byte_kind, got.byte_kind);
      compare_field("set_index", want.set_index, got.set_index);
      compare_field("echo_byte", want.echo_byte, got.echo_byte);
      compare_field("set_start", want.set_start, got.set_start);
      compare_field("set_end", want.set_end, got.set_end);
      compare_field("set_stored", want.set_stored, got.set_stored);
      compare_field("done_res", want.done_res, got.done_res);
      compare_field("status", want.status, got.status);
      compare_field("consumed_bytes", want.consumed_bytes, got.consumed_bytes);
      compare_field("seq_set_total", want.seq_set_total, got.seq_set_total);
      compare_field("pic_set_total", want.pic_set_total, got.pic_set_total);
    end
  endtask

  always @(posedge clk) begin
    if (rst === 1'b0 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen_tag.byte_kind = avcp_kind_t'(out_if.byte_kind);
      seen_tag.set_index = out_if.set_index;
      seen_tag.echo_byte = out_if.echo_byte;
      seen_tag.set_start = out_if.set_start;
      seen_tag.set_end = out_if.set_end;
      seen_tag.set_stored = out_if.set_stored;
      seen_tag.done_res = out_if.done_res;
      seen_tag.status = avcp_status_t'(out_if.status);
      seen_tag.consumed_bytes = out_if.consumed_bytes;
      seen_tag.seq_set_total = out_if.seq_set_total;
      seen_tag.pic_set_total = out_if.pic_set_total;
      check_tag(seen_tag);
    end
  end

  // result side back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && ready_stall == 0 && $urandom_range(0, 11) == 0)
        ready_stall = $urandom_range(1, 19);
      if (ready_stall > 0) begin
        out_if.ready <= 1'b0;
        ready_stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5000000;
    $display("avc_config_record_parser regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.first_byte = 1'b0;
    in_if.last_byte = 1'b0;
    cap_seq = SEQ_CAP_RESET;
    cap_pic = PIC_CAP_RESET;
    clear_parse();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_records();
    test_count_extremes();
    test_capacity_limits();
    test_long_set();
    set_capacities($urandom_range(0, 4), $urandom_range(0, 4));
    test_random_records(10);
    set_capacities($urandom_range(0, 4), $urandom_range(0, 4));
    test_random_records(10);
    test_unpaced_stream();

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_tags.size() == 0) begin
      $display("avc_config_record_parser regression: pass");
    end else begin
      $display("avc_config_record_parser regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== avc_config_record_parser.f =====
hw/rtl/avcp_pkg.sv
hw/rtl/avcp_in_if.sv
hw/rtl/avcp_out_if.sv
hw/rtl/avcp_parse.sv
hw/rtl/avc_config_record_parser.sv
bench/avc_config_record_parser_tb.sv
